### src/assert_macros.svh
// Assertion macros shared by the lexer RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that is switched off while reset is asserted.
`define KWL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs through reset.
`define KWL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KWL_ASSERT(lbl, clk, rst_n, prop, msg)
`define KWL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### src/kwl_pkg.sv
package kwl_pkg;

  // Identifier buffer size and the widths that follow from it.
  localparam int IDENT_MAX  = 16;
  localparam int IDX_W      = $clog2(IDENT_MAX);
  localparam int CNT_W      = $clog2(IDENT_MAX + 1);
  localparam int MAX_CHUNKS = (IDENT_MAX + 7) / 8;
  localparam int CHUNK_W    = $clog2(MAX_CHUNKS + 1);
  localparam int CHARS_W    = MAX_CHUNKS * 64;

  // Run queue between the scanner and the token emitter.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Token kinds.
  localparam logic [4:0] TK_PROC   = 5'd0;
  localparam logic [4:0] TK_STRUCT = 5'd1;
  localparam logic [4:0] TK_REF    = 5'd2;
  localparam logic [4:0] TK_WHILE  = 5'd3;
  localparam logic [4:0] TK_IF     = 5'd4;
  localparam logic [4:0] TK_ELSE   = 5'd5;
  localparam logic [4:0] TK_END    = 5'd6;
  localparam logic [4:0] TK_NL     = 5'd7;
  localparam logic [4:0] TK_LP     = 5'd8;
  localparam logic [4:0] TK_RP     = 5'd9;
  localparam logic [4:0] TK_LB     = 5'd10;
  localparam logic [4:0] TK_RB     = 5'd11;
  localparam logic [4:0] TK_EQ     = 5'd12;
  localparam logic [4:0] TK_COMMA  = 5'd13;
  localparam logic [4:0] TK_ARROW  = 5'd14;
  localparam logic [4:0] TK_IF0    = 5'd15;
  localparam logic [4:0] TK_NUM    = 5'd16;
  localparam logic [4:0] TK_ID     = 5'd17;
  localparam logic [4:0] TK_EOF    = 5'd18;
  localparam logic [4:0] TK_BINOP  = 5'd19;
  localparam logic [4:0] TK_ERR    = 5'd20;

  // Keyword table, first character in the low byte, zero padded.
  localparam int KW_NUM = 8;
  localparam logic [47:0] KW_TEXT [KW_NUM] = '{
    48'h0000_636f_7270,  // proc
    48'h7463_7572_7473,  // struct
    48'h0000_0066_6572,  // ref
    48'h0065_6c69_6877,  // while
    48'h0000_0000_6669,  // if
    48'h0000_6573_6c65,  // else
    48'h0000_0064_6e65,  // end
    48'h0000_0030_6669   // if0
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{
    3'd4, 3'd6, 3'd3, 3'd5, 3'd2, 3'd4, 3'd3, 3'd3
  };
  localparam logic [4:0] KW_KIND [KW_NUM] = '{
    TK_PROC, TK_STRUCT, TK_REF, TK_WHILE, TK_IF, TK_ELSE, TK_END, TK_IF0
  };

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_MINUS,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_ERROR
  } mode_t;

  // Up to two tokens caused by one input beat: a pending token closed by
  // this byte (a), then the token of the byte itself or EOF (b).
  typedef struct packed {
    logic               a_vld;
    logic [4:0]         a_kind;
    logic [31:0]        a_value;
    logic [CHARS_W-1:0] a_chars;
    logic [4:0]         a_len;
    logic [CHUNK_W-1:0] a_last;
    logic [15:0]        a_line;
    logic [15:0]        a_col;
    logic               b_vld;
    logic [4:0]         b_kind;
    logic [31:0]        b_value;
    logic [15:0]        b_line;
    logic [15:0]        b_col;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] value;
    logic [63:0] chars;
    logic [4:0]  len;
    logic        chunk;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } res_t;

endpackage

### src/kwl_front.sv
module kwl_front
  import kwl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    in_tuser,
  input  logic [7:0] in_tdata,
  input  q_stat_t q_stat,
  output logic    q_push,
  output run_t    q_run
);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  mode_t       mode_r, mode_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] st_line_r, st_line_nxt;
  logic [15:0] st_col_r, st_col_nxt;
  logic [7:0]  buf_r [IDENT_MAX];

  logic             accept;
  logic [7:0]       ch;
  logic             buf_we;
  logic [IDX_W-1:0] buf_idx;
  logic [15:0]      col_inc;
  logic [15:0]      line_inc;
  logic [31:0]      digit;

  // Token closed by the current byte.
  logic               ft_vld;
  logic [4:0]         ft_kind;
  logic [31:0]        ft_value;
  logic [CHARS_W-1:0] ft_chars;
  logic [CHARS_W-1:0] word;
  logic [4:0]         ft_len;
  logic [CHUNK_W-1:0] ft_last;
  logic [CNT_W:0]     chunk_sum;
  logic [CNT_W:0]     n_chunks;
  logic               kw_hit;
  logic [4:0]         kw_kind;

  // Handling of the byte as a fresh byte.
  logic        fr_emit;
  logic [4:0]  fr_kind;
  logic [31:0] fr_value;
  mode_t       fr_mode;
  logic        fr_start;
  logic        fr_col;
  logic        fr_newline;
  logic        use_fresh;
  logic        do_flush;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign ch        = in_tdata;
  assign col_inc   = (col_r != 16'hFFFF) ? col_r + 16'd1 : col_r;
  assign line_inc  = (line_r != 16'hFFFF) ? line_r + 16'd1 : line_r;
  assign digit     = 32'(ch - CH_ZERO);

  // Pending token and keyword lookup.
  always_comb begin
    word = '0;
    for (int i = 0; i < IDENT_MAX; i++) begin
      if (CNT_W'(i) < cnt_r) begin
        word[i*8 +: 8] = buf_r[i];
      end
    end
    kw_hit  = 1'b0;
    kw_kind = TK_ID;
    for (int k = 0; k < KW_NUM; k++) begin
      if (!kw_hit && cnt_r == CNT_W'(KW_LEN[k]) && word[47:0] == KW_TEXT[k]) begin
        kw_hit  = 1'b1;
        kw_kind = KW_KIND[k];
      end
    end
    chunk_sum = (CNT_W+1)'(cnt_r) + (CNT_W+1)'(7);
    n_chunks  = chunk_sum >> 3;

    ft_vld   = 1'b1;
    ft_kind  = TK_NUM;
    ft_value = '0;
    ft_chars = '0;
    ft_len   = '0;
    ft_last  = '0;
    unique case (mode_r)
      MODE_NUM: begin
        ft_value = acc_r;
      end
      MODE_IDENT: begin
        ft_kind = kw_kind;
        if (!kw_hit) begin
          ft_chars = word;
          ft_len   = 5'(cnt_r);
          ft_last  = CHUNK_W'(n_chunks - 1'b1);
        end
      end
      MODE_MINUS: begin
        ft_kind  = TK_BINOP;
        ft_value = 32'(CH_MINUS);
      end
      MODE_SLASH: begin
        ft_kind  = TK_BINOP;
        ft_value = 32'(CH_SLASH);
      end
      default: begin
        ft_vld = 1'b0;
      end
    endcase
  end

  // Classification of a byte that starts something new.
  always_comb begin
    fr_emit    = 1'b1;
    fr_kind    = TK_ERR;
    fr_value   = '0;
    fr_mode    = MODE_IDLE;
    fr_start   = 1'b0;
    fr_col     = 1'b1;
    fr_newline = 1'b0;
    unique case (ch)
      CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: fr_emit = 1'b0;
      CH_NL: begin
        fr_kind    = TK_NL;
        fr_col     = 1'b0;
        fr_newline = 1'b1;
      end
      CH_LPAREN: fr_kind = TK_LP;
      CH_RPAREN: fr_kind = TK_RP;
      CH_LBRACK: fr_kind = TK_LB;
      CH_RBRACK: fr_kind = TK_RB;
      CH_EQUAL:  fr_kind = TK_EQ;
      CH_COMMA:  fr_kind = TK_COMMA;
      CH_PLUS, CH_STAR: begin
        fr_kind  = TK_BINOP;
        fr_value = 32'(ch);
      end
      CH_MINUS: begin
        fr_emit  = 1'b0;
        fr_mode  = MODE_MINUS;
        fr_start = 1'b1;
      end
      CH_SLASH: begin
        fr_emit  = 1'b0;
        fr_mode  = MODE_SLASH;
        fr_start = 1'b1;
      end
      default: begin
        fr_start = 1'b1;
        if (is_digit(ch)) begin
          fr_emit = 1'b0;
          fr_mode = MODE_NUM;
        end else if (is_alpha(ch)) begin
          fr_emit = 1'b0;
          fr_mode = MODE_IDENT;
        end else begin
          fr_mode = MODE_ERROR;
          fr_col  = 1'b0;
        end
      end
    endcase
  end

  // Scanner step.
  always_comb begin
    mode_nxt    = mode_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    st_line_nxt = st_line_r;
    st_col_nxt  = st_col_r;
    buf_we      = 1'b0;
    buf_idx     = cnt_r[IDX_W-1:0];
    use_fresh   = 1'b0;
    do_flush    = 1'b0;
    q_run       = '0;

    if (accept) begin
      if (mode_r == MODE_ERROR) begin
        q_run.b_vld  = 1'b1;
        q_run.b_kind = TK_ERR;
        q_run.b_line = st_line_r;
        q_run.b_col  = st_col_r;
      end else if (in_tuser) begin
        do_flush     = 1'b1;
        q_run.b_vld  = 1'b1;
        q_run.b_kind = TK_EOF;
        q_run.b_line = line_r;
        q_run.b_col  = col_r;
        mode_nxt     = MODE_IDLE;
        acc_nxt      = '0;
        cnt_nxt      = '0;
        line_nxt     = 16'd1;
        col_nxt      = '0;
        st_line_nxt  = 16'd1;
        st_col_nxt   = '0;
      end else begin
        unique case (mode_r)
          MODE_COMMENT: begin
            if (ch == CH_NL) begin
              line_nxt = line_inc;
              col_nxt  = '0;
              mode_nxt = MODE_IDLE;
            end else begin
              col_nxt = col_inc;
            end
          end
          MODE_NUM: begin
            if (is_digit(ch)) begin
              acc_nxt = (acc_r << 3) + (acc_r << 1) + digit;
              col_nxt = col_inc;
            end else begin
              do_flush  = 1'b1;
              use_fresh = 1'b1;
            end
          end
          MODE_IDENT: begin
            if (is_digit(ch) || is_alpha(ch)) begin
              // Characters beyond the buffer only move the column.
              if (cnt_r < CNT_W'(IDENT_MAX)) begin
                buf_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
              col_nxt = col_inc;
            end else begin
              do_flush  = 1'b1;
              use_fresh = 1'b1;
            end
          end
          MODE_MINUS: begin
            if (ch == CH_GT) begin
              q_run.b_vld  = 1'b1;
              q_run.b_kind = TK_ARROW;
              q_run.b_line = st_line_r;
              q_run.b_col  = st_col_r;
              col_nxt      = col_inc;
              mode_nxt     = MODE_IDLE;
            end else begin
              do_flush  = 1'b1;
              use_fresh = 1'b1;
            end
          end
          MODE_SLASH: begin
            if (ch == CH_SLASH) begin
              mode_nxt = MODE_COMMENT;
              col_nxt  = col_inc;
            end else begin
              do_flush  = 1'b1;
              use_fresh = 1'b1;
            end
          end
          default: begin
            use_fresh = 1'b1;
          end
        endcase

        if (use_fresh) begin
          mode_nxt = fr_mode;
          if (fr_start) begin
            st_line_nxt = line_r;
            st_col_nxt  = col_r;
          end
          if (fr_col) begin
            col_nxt = col_inc;
          end
          if (fr_newline) begin
            line_nxt = line_inc;
            col_nxt  = '0;
          end
          if (fr_mode == MODE_NUM) begin
            acc_nxt = digit;
          end
          if (fr_mode == MODE_IDENT) begin
            buf_we  = 1'b1;
            buf_idx = '0;
            cnt_nxt = CNT_W'(1);
          end
          q_run.b_vld   = fr_emit;
          q_run.b_kind  = fr_kind;
          q_run.b_value = fr_value;
          q_run.b_line  = line_r;
          q_run.b_col   = col_r;
        end
      end

      if (do_flush && ft_vld) begin
        q_run.a_vld   = 1'b1;
        q_run.a_kind  = ft_kind;
        q_run.a_value = ft_value;
        q_run.a_chars = ft_chars;
        q_run.a_len   = ft_len;
        q_run.a_last  = ft_last;
        q_run.a_line  = st_line_r;
        q_run.a_col   = st_col_r;
      end
    end
  end

  assign q_push = q_run.a_vld || q_run.b_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      cnt_r     <= '0;
      line_r    <= 16'd1;
      col_r     <= '0;
      st_line_r <= 16'd1;
      st_col_r  <= '0;
    end else begin
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      st_line_r <= st_line_nxt;
      st_col_r  <= st_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[buf_idx] <= ch;
    end
  end

endmodule

### src/kwl_queue.sv
module kwl_queue
  import kwl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  run_t    push_run,
  input  logic    pop,
  output run_t    head,
  output q_stat_t stat
);

  run_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

### src/kwl_back.sv
module kwl_back
  import kwl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  run_t    head,
  input  q_stat_t q_stat,
  output logic    q_pop,
  output logic    res_vld,
  input  logic    res_rdy,
  output res_t    res
);

  logic               phase_b_r, phase_b_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic               res_vld_r, res_vld_nxt;
  res_t               res_r;
  res_t               cur;
  logic               in_b;
  logic               a_done;
  logic               issue;
  logic [63:0]        chunk_chars;

  assign in_b   = phase_b_r || !head.a_vld;
  assign a_done = (chunk_r == head.a_last);
  assign issue  = !q_stat.empty && (!res_vld_r || res_rdy);
  assign q_pop  = issue && (in_b || (a_done && !head.b_vld));

  always_comb begin
    chunk_chars = '0;
    for (int k = 0; k < MAX_CHUNKS; k++) begin
      if (chunk_r == CHUNK_W'(k)) begin
        chunk_chars = head.a_chars[k*64 +: 64];
      end
    end

    if (in_b) begin
      cur.kind  = head.b_kind;
      cur.value = head.b_value;
      cur.chars = '0;
      cur.len   = '0;
      cur.chunk = 1'b0;
      cur.line  = head.b_line;
      cur.col   = head.b_col;
      cur.last  = 1'b1;
    end else begin
      cur.kind  = head.a_kind;
      cur.value = head.a_value;
      cur.chars = chunk_chars;
      cur.len   = head.a_len;
      cur.chunk = chunk_r[0];
      cur.line  = head.a_line;
      cur.col   = head.a_col;
      cur.last  = a_done && !head.b_vld;
    end

    phase_b_nxt = phase_b_r;
    chunk_nxt   = chunk_r;
    if (issue) begin
      if (in_b) begin
        phase_b_nxt = 1'b0;
        chunk_nxt   = '0;
      end else if (a_done) begin
        phase_b_nxt = head.b_vld;
        chunk_nxt   = '0;
      end else begin
        chunk_nxt = chunk_r + 1'b1;
      end
    end

    res_vld_nxt = res_vld_r;
    if (issue) begin
      res_vld_nxt = 1'b1;
    end else if (res_rdy) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_b_r <= 1'b0;
      chunk_r   <= '0;
      res_vld_r <= 1'b0;
    end else begin
      phase_b_r <= phase_b_nxt;
      chunk_r   <= chunk_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      res_r <= cur;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

### src/keyword_token_lexer.sv
// Channel  Dir  Ports                         Contents
// in       in   in_tvalid/in_tready           one source byte or the end marker per beat
//               in_tuser, in_tdata            see port comments
// out      out  out_tvalid/out_tready         one token per beat, last token of a run flagged
//               out_tuser, out_tdata, out_tlast
//
// The scanner takes one byte per cycle while the run queue has room.
// The emitter sends one token per cycle unless the output stalls; a byte that
// closes an identifier and emits another token gives it up to three tokens,
// which the four-entry run queue absorbs. Output stalls back up via the queue.
// Reset (rst_n low, synchronous) empties the queue and the output register
// and returns the scanner to line 1, column 0.
`include "assert_macros.svh"

module keyword_token_lexer
  import kwl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] src_byte
  input  logic         in_tuser,   // [0] req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [31:0] token_value, [95:32] ident_chars,
                                   // [100:96] ident_length, [101] chunk_index,
                                   // [117:102] line_number, [133:118] column_number
  output logic [4:0]   out_tuser,  // [4:0] token_kind
  output logic         out_tlast   // last_of_run
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  run_t    run;
  run_t    head;
  res_t    res;

  kwl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_run     (run)
  );

  kwl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_run (run),
    .pop      (q_pop),
    .head     (head),
    .stat     (q_stat)
  );

  kwl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .res_vld (out_tvalid),
    .res_rdy (out_tready),
    .res     (res)
  );

  assign out_tdata = {2'b00, res.col, res.line, res.chunk, res.len, res.chars, res.value};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

  `KWL_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_tvalid && in_tready, "reset left tokens pending")
  `KWL_ASSERT(a_run_nonempty, clk, rst_n, q_push |-> run.a_vld || run.b_vld, "empty run pushed")
  `KWL_ASSERT(a_no_pop_empty, clk, rst_n, q_pop |-> !q_stat.empty, "pop from empty run queue")
  `KWL_ASSERT(a_final_kinds, clk, rst_n, out_tvalid && (out_tuser == TK_ERR || out_tuser == TK_EOF) |-> out_tlast, "error or EOF token not last of run")

endmodule
